// File: rtl/web_pkg.sv
package web_pkg;

  localparam int unsigned ROWS_DEF = 1024;
  localparam int unsigned DIM_DEF  = 16;

  localparam int WORD_W     = 16;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 4;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 32;
  localparam int VAL_W      = 32;
  localparam int LEN_W      = 8;
  localparam int UCOL_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int unsigned ITEM_Q_DEPTH = 4;
  localparam int unsigned RES_Q_DEPTH  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USED_COLUMNS = 2'd0,
    REG_BAG_LENGTH   = 2'd1,
    REG_MEAN_MODE    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_ELEMENT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic                     is_elem;
    logic                     wr_ok;
    logic                     gather_ok;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         column;
    logic signed [WORD_W-1:0] word;
    logic signed [WORD_W-1:0] weight;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [UCOL_W-1:0] used_columns;
    logic [LEN_W-1:0]  bag_length;
    logic              mean_mode;
  } cfg_t;

endpackage

// File: rtl/web_ram.sv
module web_ram
  import web_pkg::*;
#(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/web_fifo.sv
module web_fifo
  import web_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW:0]      wr_ptr_q, wr_ptr_d;
  logic [PW:0]      rd_ptr_q, rd_ptr_d;

  assign full_o  = (wr_ptr_q[PW] != rd_ptr_q[PW]) && (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]);
  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign rdata_o = mem_q[rd_ptr_q[PW-1:0]];

  assign wr_ptr_d = (push_i && !full_o) ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = (pop_i && !empty_o) ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q[PW-1:0]] <= wdata_i;
    end
  end

endmodule

// File: rtl/web_front.sv
module web_front
  import web_pkg::*;
#(
  parameter int unsigned ROWS  = ROWS_DEF,
  parameter int unsigned DIM   = DIM_DEF,
  parameter int unsigned DEPTH = ITEM_Q_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic                     opcode_i,
  input  logic [ROW_W-1:0]         row_i,
  input  logic [COL_W-1:0]         column_i,
  input  logic signed [WORD_W-1:0] table_word_i,
  input  logic signed [WORD_W-1:0] weight_i,
  output item_t                    item_o,
  output logic                     empty_o,
  input  logic                     pop_i
);

  item_t                    cls;
  logic [$bits(item_t)-1:0] q_rdata;

  // range checks are done here so the back end only steers
  always_comb begin
    cls.is_elem   = (opcode_i == OP_ELEMENT);
    cls.gather_ok = (32'(row_i) < ROWS);
    cls.wr_ok     = (32'(row_i) < ROWS) && (32'(column_i) < DIM);
    cls.row       = row_i;
    cls.column    = column_i;
    cls.word      = table_word_i;
    cls.weight    = weight_i;
  end

  web_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(DEPTH)
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(cls),
    .full_o (full_o),
    .pop_i  (pop_i),
    .rdata_o(q_rdata),
    .empty_o(empty_o)
  );

  assign item_o = item_t'(q_rdata);

endmodule

// File: rtl/web_back.sv
module web_back
  import web_pkg::*;
#(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned DIM  = DIM_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    item_empty_i,
  output logic    item_pop_o,
  output result_t res_o,
  output logic    res_push_o,
  input  logic    res_full_i
);

  localparam int unsigned TBL_DEPTH = ROWS * DIM;
  localparam int AW    = $clog2(TBL_DEPTH);
  localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int NW    = $clog2(DIM + 1);
  localparam int DIVCW = $clog2(ACC_W);

  back_state_e state_q, state_d;

  logic [NW-1:0]    eff_cols;
  logic [LEN_W-1:0] eff_len;

  logic [AW-1:0]            base_q;
  logic signed [WORD_W-1:0] weight_q;
  logic [NW-1:0]            cols_q;
  logic [NW-1:0]            cnt_q;
  logic [LEN_W-1:0]         seen_q;
  logic [LEN_W-1:0]         seen_inc;
  logic                     bag_close;

  logic                     a_v_q, p_v_q;
  logic [CW-1:0]            a_col_q, p_col_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q [DIM];

  logic [NW-1:0]      col_q;
  logic               neg_q;
  logic [ACC_W-1:0]   mag_q;
  logic [LEN_W-1:0]   rem_q;
  logic [DIVCW-1:0]   div_cnt_q;
  logic [LEN_W:0]     div_trial;
  logic               div_ge;
  logic               last_col;
  logic signed [ACC_W-1:0] acc_sel;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [ACC_W:0]   up_sum;
  logic [ACC_W-8:0] q_neg;
  logic [ACC_W-9:0] q_pos;

  always_comb begin
    if (cfg_i.used_columns == '0) begin
      eff_cols = NW'(1);
    end else if (32'(cfg_i.used_columns) > DIM) begin
      eff_cols = NW'(DIM);
    end else begin
      eff_cols = NW'(cfg_i.used_columns);
    end
    eff_len = (cfg_i.bag_length == '0) ? LEN_W'(1) : cfg_i.bag_length;
  end

  assign seen_inc  = seen_q + 1'b1;
  assign bag_close = (seen_inc == '0) || (seen_inc >= eff_len);
  assign last_col  = (col_q == cols_q - 1'b1);
  assign acc_sel   = acc_q[col_q[CW-1:0]];

  // one quotient bit per cycle, remainder stays below the bag length
  assign div_trial = {rem_q, mag_q[ACC_W-1]};
  assign div_ge    = (div_trial >= {1'b0, eff_len});

  // floor shift of a negative value is a ceiling shift of its magnitude
  assign up_sum = {1'b0, mag_q} + (ACC_W + 1)'(255);
  assign q_neg  = up_sum[ACC_W:8];
  assign q_pos  = mag_q[ACC_W-1:8];

  always_comb begin
    res_o.column = COL_W'(col_q);
    res_o.last   = last_col;
    if (neg_q) begin
      if (q_neg > (ACC_W - 7)'(32'h8000_0000)) begin
        res_o.value = 32'sh8000_0000;
      end else begin
        res_o.value = -$signed(q_neg[VAL_W-1:0]);
      end
    end else begin
      if (q_pos > (ACC_W - 8)'(32'h7FFF_FFFF)) begin
        res_o.value = 32'sh7FFF_FFFF;
      end else begin
        res_o.value = $signed(q_pos[VAL_W-1:0]);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!item_empty_i && item_i.is_elem) begin
          state_d = item_i.gather_ok ? ST_MAC : ST_DRAIN;
        end
      end
      ST_MAC: begin
        if (cnt_q == cols_q - 1'b1) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!a_v_q && !p_v_q) state_d = bag_close ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        state_d = cfg_i.mean_mode ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (div_cnt_q == DIVCW'(ACC_W - 1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_full_i) state_d = last_col ? ST_IDLE : ST_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_pop_o = (state_q == ST_IDLE) && !item_empty_i;
    ram_we     = item_pop_o && !item_i.is_elem && item_i.wr_ok;
    ram_waddr  = AW'(32'(item_i.row) * DIM + 32'(item_i.column));
    ram_re     = (state_q == ST_MAC);
    ram_raddr  = base_q + AW'(cnt_q);
    res_push_o = (state_q == ST_EMIT) && !res_full_i;
  end

  web_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(item_i.word),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= '0;
      a_v_q   <= 1'b0;
      p_v_q   <= 1'b0;
      for (int i = 0; i < DIM; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      a_v_q   <= ram_re;
      p_v_q   <= a_v_q;
      if (p_v_q) begin
        acc_q[p_col_q] <= acc_q[p_col_q] + ACC_W'(prod_q);
      end
      if (state_q == ST_DRAIN && !a_v_q && !p_v_q) begin
        seen_q <= bag_close ? '0 : seen_inc;
      end
      if (res_push_o && last_col) begin
        for (int i = 0; i < DIM; i++) acc_q[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_col_q <= cnt_q[CW-1:0];
    p_col_q <= a_col_q;
    prod_q  <= weight_q * $signed(ram_rdata);
    unique case (state_q)
      ST_IDLE: begin
        base_q   <= AW'(32'(item_i.row) * DIM);
        weight_q <= item_i.weight;
        cols_q   <= eff_cols;
        cnt_q    <= '0;
        col_q    <= '0;
      end
      ST_MAC: begin
        cnt_q <= cnt_q + 1'b1;
      end
      ST_LOAD: begin
        neg_q     <= acc_sel[ACC_W-1];
        mag_q     <= acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
        rem_q     <= '0;
        div_cnt_q <= '0;
      end
      ST_DIV: begin
        mag_q     <= {mag_q[ACC_W-2:0], div_ge};
        rem_q     <= div_ge ? LEN_W'(div_trial - {1'b0, eff_len}) : div_trial[LEN_W-1:0];
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      ST_EMIT: begin
        if (!res_full_i) col_q <= col_q + 1'b1;
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

endmodule

// File: rtl/weighted_embedding_bag.sv
// Weighted embedding bag: a ROWS x DIM table of signed Q8.8 words, loaded by
// table-write items, and bag elements that add weight * row into per-column
// 48-bit accumulators. Items queue at the input and are executed one at a
// time. A bag element's columns are read through the single table read port,
// which feeds one multiply-accumulate, one column per cycle. When a bag closes
// each column in use is finished and written to the result queue: it passes
// through a load state and an emit state, and in mean mode also through a
// bit-serial divider that produces one quotient bit per cycle.
// Results are floored by 8 bits and saturated to signed 32 bits. The table
// has no reset; rows must be written before they are gathered. Configuration
// writes are always accepted and must only be made while the block is idle.
module weighted_embedding_bag
  import web_pkg::*;
#(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned DIM  = DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic                     opcode_i,
  input  logic [ROW_W-1:0]         row_i,
  input  logic [COL_W-1:0]         column_i,
  input  logic signed [WORD_W-1:0] table_word_i,
  input  logic signed [WORD_W-1:0] weight_i,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic [COL_W-1:0]         out_column_o,
  output logic signed [VAL_W-1:0]  out_value_o,
  output logic                     out_last_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  cfg_t    cfg_q;
  item_t   item;
  logic    item_empty, item_pop;
  result_t res_item;
  logic    res_push, res_full;
  logic [$bits(result_t)-1:0] res_rdata;
  result_t res_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.used_columns <= UCOL_W'(16);
      cfg_q.bag_length   <= LEN_W'(1);
      cfg_q.mean_mode    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_USED_COLUMNS: cfg_q.used_columns <= cfg_data_i[UCOL_W-1:0];
        REG_BAG_LENGTH:   cfg_q.bag_length   <= cfg_data_i[LEN_W-1:0];
        REG_MEAN_MODE:    cfg_q.mean_mode    <= cfg_data_i[0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  web_front #(
    .ROWS (ROWS),
    .DIM  (DIM),
    .DEPTH(ITEM_Q_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .opcode_i    (opcode_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .table_word_i(table_word_i),
    .weight_i    (weight_i),
    .item_o      (item),
    .empty_o     (item_empty),
    .pop_i       (item_pop)
  );

  web_back #(
    .ROWS(ROWS),
    .DIM (DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .res_o       (res_item),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  web_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_item),
    .full_o (res_full),
    .pop_i  (pop_i),
    .rdata_o(res_rdata),
    .empty_o(empty_o)
  );

  assign res_head     = result_t'(res_rdata);
  assign out_column_o = res_head.column;
  assign out_value_o  = res_head.value;
  assign out_last_o   = res_head.last;

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result written into a full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> !item_empty)
    else $error("item taken from an empty queue");

  a_last_ends_bag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_item.last) |=> !res_push)
    else $error("result beat follows the last beat of a bag");

  a_no_pop_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !item_pop)
    else $error("item taken while a bag is being emitted");

endmodule
